>>> rtl/core/oair_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oair_pkg
// Shared types and codes for the ordered array insert/remove block.
// ----------------------------------------------------------------------------
package oair_pkg;

  localparam int unsigned VAL_W = 32;
  // position compare width, covers counts up to 256
  localparam int unsigned POS_W = 9;

  typedef enum logic [2:0] {
    MODE_PUSH   = 3'd0,
    MODE_POP    = 3'd1,
    MODE_INSERT = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_READ   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic             ins;     // open a slot at wr_pos, shift up above it
    logic             rem;     // close the slot at rd_pos, shift down above it
    logic [POS_W-1:0] wr_pos;
    logic             rd_en;
    logic [POS_W-1:0] rd_pos;
  } cell_ctrl_t;

endpackage

>>> rtl/core/oair_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oair_cell
// One slot of the element chain: loads the new value, takes its lower or
// upper neighbor, or holds, and drives its element onto the read bus.
// ----------------------------------------------------------------------------
module oair_cell
  import oair_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic                    clk_i,
  input  cell_ctrl_t              ctrl_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic signed [VAL_W-1:0] left_i,
  input  logic signed [VAL_W-1:0] right_i,
  output logic signed [VAL_W-1:0] elem_o,
  output logic signed [VAL_W-1:0] rd_o
);

  localparam logic [POS_W-1:0] MyIdx = POS_W'(IDX);

  logic signed [VAL_W-1:0] elem_q;
  logic signed [VAL_W-1:0] elem_d;

  always_comb begin
    elem_d = elem_q;
    if (ctrl_i.ins) begin
      if (MyIdx == ctrl_i.wr_pos) begin
        elem_d = value_i;
      end else if (MyIdx > ctrl_i.wr_pos) begin
        elem_d = left_i;
      end
    end else if (ctrl_i.rem) begin
      if (MyIdx >= ctrl_i.rd_pos) begin
        elem_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
  end

  assign elem_o = elem_q;
  // zero unless this slot is the one being read
  assign rd_o   = (ctrl_i.rd_en && (MyIdx == ctrl_i.rd_pos)) ? elem_q : '0;

endmodule

>>> rtl/core/ordered_array_insert_remove.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_insert_remove
// Ordered array of signed values with push, pop, insert, remove and read.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one operation per item:
//   mode_i, position_i and item_value_i. Output channel (out_valid_o /
//   out_stall_i) returns one result item per input item: out_value_o,
//   count_o (elements stored afterwards) and status_o.
//   The elements live in a row of CAPACITY cells; an insert or remove moves
//   every affected cell one place at once, and the read value is
//   gathered from the cells over an or-bus.
//   Result: registered, it appears in the cycle after the item is accepted.
//   Throughput: one item per cycle while no result waits under out_stall_i,
//   set by the cell shift and the output register.
//   Stall: while a result waits under out_stall_i, in_stall_o is raised and
//   the array holds its contents; it drops as soon as the result is taken.
//   Reset: clears the count and the output valid; element storage is not
//   cleared and is only ever read below the count.
// ----------------------------------------------------------------------------
module ordered_array_insert_remove
  import oair_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [2:0]              mode_i,
  input  logic [7:0]              position_i,
  input  logic signed [VAL_W-1:0] item_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [VAL_W-1:0] out_value_o,
  output logic [4:0]              count_o,
  output logic [1:0]              status_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapCnt = CW'(CAPACITY);

  logic                    in_acc;
  logic [CW-1:0]           fill_q;
  logic [CW-1:0]           fill_d;
  logic                    out_valid_q;
  logic                    out_valid_d;
  logic signed [VAL_W-1:0] out_value_q;
  logic [4:0]              count_q;
  status_e                 status_q;
  status_e                 status_d;
  logic signed [VAL_W-1:0] rd_val;
  cell_ctrl_t              ctrl;
  logic                    ins;
  logic                    rem;
  logic [POS_W-1:0]        pos_ext;
  logic [POS_W-1:0]        cnt_ext;
  logic                    full;
  logic                    empty;

  logic signed [VAL_W-1:0] elem   [CAPACITY];
  logic signed [VAL_W-1:0] rd_bus [CAPACITY];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign pos_ext = POS_W'(position_i);
  assign cnt_ext = POS_W'(fill_q);
  assign full    = (fill_q == CapCnt);
  assign empty   = (fill_q == '0);

  always_comb begin
    ins          = 1'b0;
    rem          = 1'b0;
    fill_d       = fill_q;
    status_d     = ST_OK;
    ctrl.wr_pos  = cnt_ext;
    ctrl.rd_en   = 1'b0;
    ctrl.rd_pos  = pos_ext;
    case (mode_e'(mode_i))
      MODE_PUSH: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ins    = 1'b1;
          fill_d = fill_q + CW'(1);
        end
      end
      MODE_POP: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          ctrl.rd_en  = 1'b1;
          ctrl.rd_pos = cnt_ext - POS_W'(1);
          fill_d      = fill_q - CW'(1);
        end
      end
      MODE_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ins    = 1'b1;
          // past the end turns into an append
          if (pos_ext < cnt_ext) begin
            ctrl.wr_pos = pos_ext;
          end
          fill_d = fill_q + CW'(1);
        end
      end
      MODE_REMOVE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status_d = ST_RANGE;
        end else begin
          rem        = 1'b1;
          ctrl.rd_en = 1'b1;
          fill_d     = fill_q - CW'(1);
        end
      end
      MODE_READ: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status_d = ST_RANGE;
        end else begin
          ctrl.rd_en = 1'b1;
        end
      end
      default: begin
      end
    endcase
    ctrl.ins = ins && in_acc;
    ctrl.rem = rem && in_acc;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VAL_W-1:0] left_v;
    logic signed [VAL_W-1:0] right_v;
    if (g == 0) begin : g_first
      assign left_v = item_value_i;
    end else begin : g_mid
      assign left_v = elem[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_v = elem[g];
    end else begin : g_inner
      assign right_v = elem[g+1];
    end
    oair_cell #(
      .IDX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .value_i(item_value_i),
      .left_i (left_v),
      .right_i(right_v),
      .elem_o (elem[g]),
      .rd_o   (rd_bus[g])
    );
  end

  // at most one cell drives a nonzero value
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_val = rd_val | rd_bus[i];
    end
  end

  assign out_valid_d = in_acc ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_value_q <= rd_val;
      count_q     <= 5'(fill_d);
      status_q    <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign count_o     = count_q;
  assign status_o    = status_q;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CapCnt)
    else $error("fill count beyond capacity");

  a_push_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (mode_i == MODE_PUSH) && !full |=> fill_q == $past(fill_q) + CW'(1))
    else $error("push did not grow the count");

  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == ST_FULL) |-> full)
    else $error("full status reported while not full");

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q != ST_OK) |-> out_value_q == '0)
    else $error("error result carries a value");

  a_stall_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(fill_q) || !$past(in_stall_o))
    else $error("array changed while stalled");

endmodule
